FILE: src/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants for the keyed record table
// Operation and status codes, the packed field layout of the stream
// payloads and the flag group that the scan unit reports.
// ----------------------------------------------------------------------------
package krt_pkg;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_SEARCH   = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int AGE_W     = 8;
    localparam int NAME_IN_W = 64;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 7;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 88;

    // What the scan unit has found so far.
    typedef struct packed {
        logic hit;
        logic free_found;
    } scan_flags_t;

endpackage

FILE: src/keyed_record_table_core.sv
// ----------------------------------------------------------------------------
// keyed_record_table_core: keyed record table with insert, delete, search
// A table of ENTRIES record slots held in one RAM and walked by a scan
// sequencer that feeds a shared key compare unit.
// ----------------------------------------------------------------------------
// Each item is one operation on the table: insert a record, delete a record
// by key, or search by key; every item yields exactly one result item. The
// table lives in a single synchronous RAM whose word holds a valid mark, the
// 32-bit key, the 8-bit age and the packed name. Every operation walks all
// ENTRIES slots, one RAM read per cycle, through one compare unit that
// remembers the lowest matching valid slot and the lowest free slot. After
// an item is accepted, s_tready stays low through the scan, whose RAM read is
// registered, and through the final cycle, so no new item is accepted until
// the last one has been scanned and settled. Insert, delete and the result
// are settled in the final cycle, which also writes the RAM when needed. The
// result sits in an output register, so the next item can be accepted while
// it waits to be taken; the final cycle of that next item waits until the
// earlier result has been taken, and s_tready stays low meanwhile. After
// reset the block clears the valid marks of the whole RAM and keeps
// s_tready low during that pass. Slot numbers above 127 are reported by
// their low seven bits, and only the low NAME_BYTES bytes of a name are
// stored.
module keyed_record_table_core #(
    parameter int ENTRIES    = 128,
    parameter int NAME_BYTES = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // op[1:0], student_id[33:2], age[41:34], name_bytes[105:42], zero pad
    input  logic [krt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // status[1:0], slot[8:2], found_age[16:9], found_name[80:17], zero pad
    output logic [krt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import krt_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int NAME_W = 8 * NAME_BYTES;
    localparam int WORD_W = KEY_W + AGE_W + NAME_W + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rvalid_reg;
    logic [IDX_W-1:0]   ridx_reg;

    // Captured input item.
    op_t                op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic [NAME_W-1:0]  name_reg, name_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    status_t            status_reg, status_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [AGE_W-1:0]   fage_reg, fage_next;
    logic [NAME_IN_W-1:0] fname_reg, fname_next;

    // RAM ports.
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    // Scan unit.
    logic               scan_start;
    scan_flags_t        scan_flags;
    logic [IDX_W-1:0]   hit_idx, free_idx;
    logic [WORD_W-1:0]  hit_word;

    logic [IDX_W+SLOT_W-1:0]  hit_slot_ext, free_slot_ext;
    logic [NAME_W+NAME_IN_W-1:0] hit_name_ext;
    logic [NAME_IN_W-1:0]     s_name;

    assign s_name        = s_tdata[105:42];
    assign hit_slot_ext  = {{SLOT_W{1'b0}}, hit_idx};
    assign free_slot_ext = {{SLOT_W{1'b0}}, free_idx};
    assign hit_name_ext  = {{NAME_IN_W{1'b0}}, hit_word[WORD_W-1 -: NAME_W]};

    krt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    krt_scan #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_start),
        .rvalid   (rvalid_reg),
        .ridx     (ridx_reg),
        .rword    (ram_rdata),
        .key      (key_reg),
        .flags    (scan_flags),
        .hit_idx  (hit_idx),
        .free_idx (free_idx),
        .hit_word (hit_word)
    );

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        age_next     = age_reg;
        name_next    = name_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        slot_next    = slot_reg;
        fage_next    = fage_reg;
        fname_next   = fname_reg;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg[IDX_W-1:0];
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = cnt_reg[IDX_W-1:0];
        scan_start   = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                // Zero one word per cycle; the valid mark is bit zero.
                ram_we = 1'b1;
                if (cnt_reg == CNT_W'(ENTRIES - 1)) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tdata[1:0]);
                    key_next   = s_tdata[33:2];
                    age_next   = s_tdata[41:34];
                    name_next  = s_name[NAME_W-1:0];
                    cnt_next   = '0;
                    scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // The last read's data is taken by the scan unit in the
                // cycle the counter reaches ENTRIES.
                if (cnt_reg != CNT_W'(ENTRIES)) begin
                    ram_re   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    status_next  = ST_MISSING;
                    slot_next    = '0;
                    fage_next    = '0;
                    fname_next   = '0;
                    case (op_reg)
                        OP_INSERT: begin
                            if (scan_flags.hit) begin
                                status_next = ST_DUP;
                            end else if (!scan_flags.free_found) begin
                                status_next = ST_FULL;
                            end else begin
                                ram_we      = 1'b1;
                                ram_waddr   = free_idx;
                                ram_wdata   = {name_reg, age_reg, key_reg, 1'b1};
                                status_next = ST_OK;
                                slot_next   = free_slot_ext[SLOT_W-1:0];
                            end
                        end
                        OP_DELETE: begin
                            if (scan_flags.hit) begin
                                ram_we      = 1'b1;
                                ram_waddr   = hit_idx;
                                ram_wdata   = {hit_word[WORD_W-1:1], 1'b0};
                                status_next = ST_OK;
                                slot_next   = hit_slot_ext[SLOT_W-1:0];
                            end
                        end
                        OP_SEARCH: begin
                            if (scan_flags.hit) begin
                                status_next = ST_OK;
                                slot_next   = hit_slot_ext[SLOT_W-1:0];
                                fage_next   = hit_word[KEY_W+AGE_W:KEY_W+1];
                                fname_next  = hit_name_ext[NAME_IN_W-1:0];
                            end
                        end
                        default: begin
                            // Reserved operation: no change, answered as not found.
                            status_next = ST_MISSING;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rvalid_reg  <= ram_re;
            m_valid_reg <= m_valid_next;
        end
        ridx_reg  <= ram_raddr;
        op_reg    <= op_next;
        key_reg   <= key_next;
        age_reg   <= age_next;
        name_reg  <= name_next;
        status_reg <= status_next;
        slot_reg  <= slot_next;
        fage_reg  <= fage_next;
        fname_reg <= fname_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, fname_reg, fage_reg, slot_reg, status_reg};

endmodule

FILE: src/krt_ram.sv
// ----------------------------------------------------------------------------
// krt_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/krt_scan.sv
// ----------------------------------------------------------------------------
// krt_scan: key compare and first-free tracking unit
// Looks at one table entry per cycle while rvalid is high and keeps the
// lowest matching valid entry and the lowest free entry seen since the last start.
// ----------------------------------------------------------------------------
module krt_scan #(
    parameter int ENTRIES    = 128,
    parameter int NAME_BYTES = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic                                   rvalid,
    input  logic [$clog2(ENTRIES)-1:0]             ridx,
    input  logic [krt_pkg::KEY_W+krt_pkg::AGE_W+8*NAME_BYTES:0] rword,
    input  logic [krt_pkg::KEY_W-1:0]              key,
    output krt_pkg::scan_flags_t                   flags,
    output logic [$clog2(ENTRIES)-1:0]             hit_idx,
    output logic [$clog2(ENTRIES)-1:0]             free_idx,
    output logic [krt_pkg::KEY_W+krt_pkg::AGE_W+8*NAME_BYTES:0] hit_word
);
    import krt_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WORD_W = KEY_W + AGE_W + 8 * NAME_BYTES + 1;

    scan_flags_t       flags_reg, flags_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [WORD_W-1:0] hit_word_reg, hit_word_next;
    logic              entry_valid;
    logic              key_eq;

    assign entry_valid = rword[0];
    assign key_eq      = (rword[KEY_W:1] == key);

    always_comb begin
        flags_next    = flags_reg;
        hit_idx_next  = hit_idx_reg;
        free_idx_next = free_idx_reg;
        hit_word_next = hit_word_reg;
        if (start) begin
            flags_next = '0;
        end else if (rvalid) begin
            if (entry_valid && key_eq && !flags_reg.hit) begin
                flags_next.hit = 1'b1;
                hit_idx_next   = ridx;
                hit_word_next  = rword;
            end
            if (!entry_valid && !flags_reg.free_found) begin
                flags_next.free_found = 1'b1;
                free_idx_next         = ridx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        hit_word_reg <= hit_word_next;
    end

    assign flags    = flags_reg;
    assign hit_idx  = hit_idx_reg;
    assign free_idx = free_idx_reg;
    assign hit_word = hit_word_reg;

endmodule
